### hw/rtl/dqs_pkg.sv
`default_nettype none
package dqs_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;

	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [4:0] position;
		logic [4:0] count;
	} res_t;

	// circular index step, both operands below DEPTH
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
		if (s >= (CNT_W + 1)'(DEPTH))
			s = s - (CNT_W + 1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/dqs_ram.sv
`default_nettype none
module dqs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### hw/rtl/double_ended_queue_with_search_unit.sv
`default_nettype none
// Bounded double-ended queue of DEPTH signed 32-bit words held in one
// synchronous RAM with a front index and an entry count. The response to a
// push or pop is registered the cycle after acceptance. A search reads the
// RAM through its single read port one held entry at a time from the front,
// compares each word with the key and stops at the first match or the last
// entry. A search on an empty deque and an unused command are answered
// without entering the search state. One request is in flight at a time; a
// new request is taken as soon as the response register is free or being
// drained.
module double_ended_queue_with_search_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire dqs_pkg::req_t req,
	output logic               res_valid,
	input  wire                res_stall,
	output dqs_pkg::res_t      res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	logic                        state_q;
	logic [dqs_pkg::IDX_W-1:0]   front_q;
	logic [dqs_pkg::CNT_W-1:0]   cnt_q;
	logic [dqs_pkg::CNT_W-1:0]   rd_idx_q;
	logic [dqs_pkg::WORD_W-1:0]  key_q;
	logic                        vld_s1;
	logic [dqs_pkg::CNT_W-1:0]   idx_s1;
	logic                        res_valid_q;
	dqs_pkg::res_t               res_q;

	logic                        req_acc;
	logic                        res_take;
	logic                        res_set;
	dqs_pkg::res_t               acc_res;
	logic                        full;
	logic                        empty;
	logic [dqs_pkg::IDX_W-1:0]   front_m1;
	logic                        wr_en;
	logic [dqs_pkg::IDX_W-1:0]   wr_addr;
	logic                        rd_issue;
	logic [dqs_pkg::IDX_W-1:0]   rd_addr;
	logic [dqs_pkg::WORD_W-1:0]  rd_data;
	logic                        hit;
	logic                        last;
	logic                        finish;

	assign res_take  = res_valid_q && !res_stall;
	assign req_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign req_acc   = req_valid && !req_stall;
	assign full      = cnt_q >= dqs_pkg::CNT_W'(dqs_pkg::DEPTH);
	assign empty     = cnt_q == '0;
	assign front_m1  = (front_q == '0) ? dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)
		: front_q - 1'b1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = front_m1;
		if (req_acc && !full) begin
			if (req.cmd == dqs_pkg::CMD_PUSH_FRONT) begin
				wr_en = 1'b1;
			end else if (req.cmd == dqs_pkg::CMD_PUSH_BACK) begin
				wr_en   = 1'b1;
				wr_addr = dqs_pkg::wrap_add(front_q, cnt_q);
			end
		end
	end

	// compare stage on the word read the cycle before
	assign hit    = vld_s1 && (rd_data == key_q);
	assign last   = vld_s1 && (idx_s1 == cnt_q - 1'b1);
	assign finish = hit || last;

	assign rd_issue = (state_q == ST_SRCH) && (rd_idx_q < cnt_q) && !finish;
	assign rd_addr  = dqs_pkg::wrap_add(front_q, rd_idx_q);

	assign res_set = (req_acc && !(req.cmd == dqs_pkg::CMD_SEARCH && !empty))
		|| (state_q == ST_SRCH && finish);

	always_comb begin
		acc_res        = '0;
		acc_res.status = dqs_pkg::STS_DONE;
		acc_res.count  = 5'(cnt_q);
		case (req.cmd) inside
			dqs_pkg::CMD_PUSH_FRONT, dqs_pkg::CMD_PUSH_BACK: begin
				if (full)
					acc_res.status = dqs_pkg::STS_FULL;
				else
					acc_res.count = 5'(cnt_q + 1'b1);
			end
			dqs_pkg::CMD_POP_FRONT, dqs_pkg::CMD_POP_BACK: begin
				if (empty)
					acc_res.status = dqs_pkg::STS_EMPTY;
				else
					acc_res.count = 5'(cnt_q - 1'b1);
			end
			default: ;
		endcase
	end

	dqs_ram #(
		.DEPTH(dqs_pkg::DEPTH),
		.WIDTH(dqs_pkg::WORD_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(req.value),
		.rd_en  (rd_issue),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_set)
				res_valid_q <= 1'b1;
			else if (res_take)
				res_valid_q <= 1'b0;
			vld_s1 <= rd_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (req.cmd)
							dqs_pkg::CMD_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_m1;
									cnt_q   <= cnt_q + 1'b1;
								end
							end
							dqs_pkg::CMD_PUSH_BACK: begin
								if (!full)
									cnt_q <= cnt_q + 1'b1;
							end
							dqs_pkg::CMD_POP_FRONT: begin
								if (!empty) begin
									front_q <= dqs_pkg::wrap_add(front_q,
										dqs_pkg::CNT_W'(1));
									cnt_q   <= cnt_q - 1'b1;
								end
							end
							dqs_pkg::CMD_POP_BACK: begin
								if (!empty)
									cnt_q <= cnt_q - 1'b1;
							end
							dqs_pkg::CMD_SEARCH: begin
								if (!empty) begin
									state_q  <= ST_SRCH;
									rd_idx_q <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SRCH: begin
					if (rd_issue)
						rd_idx_q <= rd_idx_q + 1'b1;
					if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue)
			idx_s1 <= rd_idx_q;
		if (state_q == ST_IDLE && req_acc) begin
			key_q <= req.value;
			res_q <= acc_res;
		end else if (state_q == ST_SRCH && finish) begin
			res_q.found    <= hit;
			res_q.position <= hit ? 5'(idx_s1 + 1'b1) : 5'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

	class deque_scoreboard;
		logic signed [dqs_pkg::WORD_W-1:0] words [dqs_pkg::DEPTH];
		int unsigned head;
		int unsigned held;
		dqs_pkg::res_t awaited [$];
		int errors;

		function new();
			head = 0;
			held = 0;
			errors = 0;
			foreach (words[i])
				words[i] = '0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function int unsigned entries();
			return held;
		endfunction

		function logic signed [dqs_pkg::WORD_W-1:0] held_word(input int unsigned k);
			return words[(head + k) % dqs_pkg::DEPTH];
		endfunction

		// advance the deque by one request and queue the response it should give
		function void note_request(input dqs_pkg::req_t r);
			dqs_pkg::res_t want;
			want = '0;
			want.status = dqs_pkg::STS_DONE;
			case (r.cmd)
				dqs_pkg::CMD_PUSH_FRONT: begin
					if (held >= dqs_pkg::DEPTH) begin
						want.status = dqs_pkg::STS_FULL;
					end else begin
						head = (head + dqs_pkg::DEPTH - 1) % dqs_pkg::DEPTH;
						words[head] = r.value;
						held++;
					end
				end
				dqs_pkg::CMD_PUSH_BACK: begin
					if (held >= dqs_pkg::DEPTH) begin
						want.status = dqs_pkg::STS_FULL;
					end else begin
						words[(head + held) % dqs_pkg::DEPTH] = r.value;
						held++;
					end
				end
				dqs_pkg::CMD_POP_FRONT: begin
					if (held == 0) begin
						want.status = dqs_pkg::STS_EMPTY;
					end else begin
						head = (head + 1) % dqs_pkg::DEPTH;
						held--;
					end
				end
				dqs_pkg::CMD_POP_BACK: begin
					if (held == 0)
						want.status = dqs_pkg::STS_EMPTY;
					else
						held--;
				end
				dqs_pkg::CMD_SEARCH: begin
					for (int unsigned i = 0; i < held; i++) begin
						if (words[(head + i) % dqs_pkg::DEPTH] == r.value) begin
							want.found = 1'b1;
							want.position = 5'(i + 1);
							break;
						end
					end
				end
				default: begin
				end
			endcase
			want.count = 5'(held);
			awaited = {awaited, want};
		endfunction

		task report_mismatch(input string what);
			$display("%0t ns: %s", $time, what);
			errors++;
		endtask

		task check_response(input dqs_pkg::res_t got);
			dqs_pkg::res_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("response %h with nothing outstanding", got));
			end else begin
				want = awaited[0];
				awaited.delete(0);
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.found !== want.found)
					report_mismatch($sformatf("found %0d, expected %0d",
						got.found, want.found));
				if (got.position !== want.position)
					report_mismatch($sformatf("position %0d, expected %0d",
						got.position, want.position));
				if (got.count !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d",
						got.count, want.count));
			end
		endtask
	endclass

	typedef enum {FILLING, DRAINING, MIXED} mix_e;

	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_REQUESTS = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	dqs_pkg::req_t req = '0;
	logic res_stall = 1'b0;
	logic req_stall;
	logic res_valid;
	dqs_pkg::res_t res;

	deque_scoreboard deque_sb = new();
	int hold_asks = 0;
	bit tx_calm = 1'b0;

	double_ended_queue_with_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #10 clk = ~clk;

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 1;
		else if (r < 85)
			return $urandom_range(2, 4);
		else if (r < 97)
			return $urandom_range(5, 15);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [dqs_pkg::WORD_W-1:0] pool_word();
		case ($urandom_range(0, 4))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return dqs_pkg::WORD_W'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic send_item(input logic [2:0] op,
		input logic signed [dqs_pkg::WORD_W-1:0] word);
		dqs_pkg::req_t item;
		item.cmd = op;
		item.value = word;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		deque_sb.note_request(item);
	endtask

	task automatic sender_pause();
		int n;
		n = 0;
		if (!tx_calm && $urandom_range(0, 99) < 50)
			n = gap_length();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (deque_sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic random_request(input mix_e mix);
		int r;
		int push_w;
		int pop_w;
		logic [2:0] op;
		logic signed [dqs_pkg::WORD_W-1:0] word;
		case (mix)
			FILLING: begin
				push_w = 60;
				pop_w = 15;
			end
			DRAINING: begin
				push_w = 15;
				pop_w = 60;
			end
			default: begin
				push_w = 35;
				pop_w = 35;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < push_w)
			op = $urandom_range(0, 1) ? dqs_pkg::CMD_PUSH_BACK : dqs_pkg::CMD_PUSH_FRONT;
		else if (r < push_w + pop_w)
			op = $urandom_range(0, 1) ? dqs_pkg::CMD_POP_BACK : dqs_pkg::CMD_POP_FRONT;
		else if (r < 96)
			op = dqs_pkg::CMD_SEARCH;
		else
			op = 3'($urandom_range(int'(dqs_pkg::CMD_SEARCH) + 1, 7));
		r = $urandom_range(0, 99);
		if (op == dqs_pkg::CMD_SEARCH && deque_sb.entries() > 0 && r < 60)
			word = deque_sb.held_word($urandom_range(0, deque_sb.entries() - 1));
		else if (r < 80)
			word = pool_word();
		else
			word = $urandom;
		send_item(op, word);
	endtask

	// response side: random stalls, calm stretches and the long hold-off
	initial begin : response_side
		int stall_left;
		int holds_done;
		int span;
		bit calm;
		stall_left = 0;
		holds_done = 0;
		span = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				deque_sb.check_response(res);
			if (holds_done != hold_asks) begin
				holds_done = hold_asks;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				if (span == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					span = $urandom_range(20, 120);
				end else begin
					span--;
				end
				if (!calm && $urandom_range(0, 99) < 30)
					stall_left = gap_length();
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : request_side
		mix_e mix;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty deque, unused codes, extremes, wrap of the front index
		send_item(dqs_pkg::CMD_POP_FRONT, 32'sd7);
		sender_pause();
		send_item(dqs_pkg::CMD_POP_BACK, -32'sd7);
		sender_pause();
		send_item(dqs_pkg::CMD_SEARCH, '0);
		sender_pause();
		for (int c = int'(dqs_pkg::CMD_SEARCH) + 1; c <= 7; c++) begin
			send_item(3'(c), -32'sd1);
			sender_pause();
		end
		send_item(dqs_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
		sender_pause();
		send_item(dqs_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
		sender_pause();
		send_item(dqs_pkg::CMD_PUSH_FRONT, '0);
		sender_pause();
		send_item(dqs_pkg::CMD_PUSH_BACK, -32'sd1);
		sender_pause();
		send_item(dqs_pkg::CMD_SEARCH, 32'sh8000_0000);
		sender_pause();
		send_item(dqs_pkg::CMD_SEARCH, 32'sd12345);
		sender_pause();
		// fill to the brim with a repeated word at the front
		for (int k = 0; k < 12; k++) begin
			if (k % 2 == 0)
				send_item(dqs_pkg::CMD_PUSH_BACK, dqs_pkg::WORD_W'(k + 100));
			else
				send_item(dqs_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
			sender_pause();
		end
		send_item(dqs_pkg::CMD_PUSH_FRONT, 32'sd1);
		sender_pause();
		send_item(dqs_pkg::CMD_PUSH_BACK, 32'sd2);
		sender_pause();
		send_item(dqs_pkg::CMD_SEARCH, 32'sd110);
		sender_pause();
		send_item(dqs_pkg::CMD_SEARCH, 32'sh7fff_ffff);
		sender_pause();
		send_item(dqs_pkg::CMD_POP_FRONT, '0);
		sender_pause();
		send_item(dqs_pkg::CMD_POP_BACK, '0);
		settle();

		mix = MIXED;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: mix = FILLING;
					1: mix = DRAINING;
					default: mix = MIXED;
				endcase
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			if (n == 300 || n == 620)
				hold_asks++;
			if (n == 450)
				settle();
			random_request(mix);
			sender_pause();
		end

		settle();
		repeat (40) @(posedge clk);
		if (deque_sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
